// ----- rtl/array_count_search_delete_defines.svh -----
// assertion macros shared by the array count/search/delete block
`ifndef ARRAY_COUNT_SEARCH_DELETE_DEFINES_SVH
`define ARRAY_COUNT_SEARCH_DELETE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ACSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acsd same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define ACSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acsd next-cycle check failed");

`endif

// ----- rtl/acsd_pkg.sv -----
// types and codes of the array count/search/delete block
`default_nettype none

package acsd_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int KIND_W = 3;
   localparam int SIZE_W = 7;

   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
   localparam logic [OP_W-1:0] OP_COUNT     = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_ALL   = 3'd5;

   localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [DATA_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [SIZE_W-1:0] result_value;
      logic [SIZE_W-1:0] table_size;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } emit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/acsd_mem.sv -----
// entry storage: one write port, one read port with registered data
`default_nettype none

module acsd_mem
   import acsd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]                      wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/acsd_walk.sv -----
// sequencer: decodes a request and walks the stored entries
`default_nettype none

module acsd_walk
   import acsd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire req_type                                req,
   input  wire logic                                   out_free,
   output emit_type                                    emit,
   output logic                                        wr_en,
   output logic      [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   output logic      [DATA_W-1:0]                      wr_data,
   output logic                                        rd_en,
   output logic      [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  wire logic [DATA_W-1:0]                      rd_data
);

   localparam int IDX_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              dv_ff, dv_in;
   logic [IDX_W-1:0]  chk_ff, chk_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              hit_ff, hit_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SIZE_W-1:0] res_ff, res_in;

   logic match;
   logic need_emit;
   logic advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         dv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         dv_ff    <= dv_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      rd_idx_ff <= rd_idx_in;
      chk_ff    <= chk_in;
      acc_ff    <= acc_in;
      hit_ff    <= hit_in;
      pos_ff    <= pos_in;
      kind_ff   <= kind_in;
      res_ff    <= res_in;
   end

   assign match     = rd_data == val_ff;
   // a new match in search flushes the one held back, which needs the output free
   assign need_emit = dv_ff && (op_ff == OP_SEARCH) && match && pend_ff;
   assign advance   = !need_emit || out_free;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      fill_in   = fill_ff;
      rd_idx_in = rd_idx_ff;
      dv_in     = dv_ff;
      chk_in    = chk_ff;
      acc_in    = acc_ff;
      hit_in    = hit_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      emit      = '0;
      wr_en     = 1'b0;
      wr_addr   = acc_ff[IDX_W-1:0];
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req.opcode;
               val_in    = req.operand_value;
               rd_idx_in = '0;
               dv_in     = 1'b0;
               acc_in    = '0;
               hit_in    = 1'b0;
               pend_in   = 1'b0;
               kind_in   = KIND_ACK;
               res_in    = '0;
               state_in  = ST_DONE;
               case (req.opcode)
                  OP_CLEAR: begin
                     fill_in = '0;
                  end
                  OP_APPEND: begin
                     if (fill_ff == FULL) begin
                        kind_in = KIND_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = fill_ff[IDX_W-1:0];
                        wr_data = req.operand_value;
                        fill_in = fill_ff + ONE;
                     end
                  end
                  OP_COUNT, OP_SEARCH, OP_DEL_FIRST, OP_DEL_ALL: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (advance) begin
               if (dv_ff) begin
                  case (op_ff)
                     OP_COUNT: begin
                        if (match) begin
                           acc_in = acc_ff + ONE;
                        end
                     end
                     OP_SEARCH: begin
                        if (match) begin
                           emit.valid            = pend_ff;
                           emit.rsp.result_kind  = KIND_FOUND;
                           emit.rsp.result_value = SIZE_W'(pos_ff);
                           emit.rsp.table_size   = SIZE_W'(fill_ff);
                           emit.rsp.last_result  = 1'b0;
                           pend_in               = 1'b1;
                           pos_in                = CNT_W'(chk_ff) + ONE;
                        end
                     end
                     default: begin
                        // compaction: kept entries move down to the write pointer
                        if (match && (op_ff == OP_DEL_ALL || !hit_ff)) begin
                           hit_in = 1'b1;
                        end else begin
                           wr_en  = 1'b1;
                           acc_in = acc_ff + ONE;
                        end
                     end
                  endcase
               end
               if (rd_idx_ff < fill_ff) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + ONE;
                  chk_in    = rd_idx_ff[IDX_W-1:0];
                  dv_in     = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
               if (!dv_ff && rd_idx_ff == fill_ff) begin
                  state_in = ST_DONE;
                  case (op_ff)
                     OP_COUNT: begin
                        kind_in = KIND_COUNT;
                        res_in  = SIZE_W'(acc_ff);
                     end
                     OP_SEARCH: begin
                        kind_in = pend_ff ? KIND_FOUND : KIND_NOT_FOUND;
                        res_in  = pend_ff ? SIZE_W'(pos_ff) : '0;
                        pend_in = 1'b0;
                     end
                     default: begin
                        kind_in = KIND_DELETED;
                        res_in  = SIZE_W'(fill_ff - acc_ff);
                        fill_in = acc_ff;
                     end
                  endcase
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.rsp.result_kind  = kind_ff;
               emit.rsp.result_value = res_ff;
               emit.rsp.table_size   = SIZE_W'(fill_ff);
               emit.rsp.last_result  = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/acsd_rsp_reg.sv -----
// result output register between the sequencer and the result channel
`default_nettype none

module acsd_rsp_reg
   import acsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire emit_type emit,
   output logic          out_free,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_free) begin
         valid_in = emit.valid;
         if (emit.valid) begin
            data_in = emit.rsp;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire

// ----- rtl/array_count_search_delete.sv -----
// top level of the array count/search/delete block
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_data: opcode, operand_value
//   rsp_      out        rsp_valid / rsp_ready  rsp_data: kind, value, size, last
//
// clear, append and unused opcodes go from accept through the done state to the result register
// count and both deletes walk the table one entry per cycle on the single memory read port;
// any op waits longer while rsp_ready is low
// a request is taken only while the sequencer is idle; a held result does not block it
// reset clears the fill count and the control state; the entries need no clearing pass
`default_nettype none
`include "array_count_search_delete_defines.svh"

module array_count_search_delete
   import acsd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              out_free;
   emit_type          emit;

   acsd_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   acsd_walk #(
      .DEPTH(DEPTH)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req_data),
      .out_free (out_free),
      .emit     (emit),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   acsd_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .out_free (out_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp_data)
   );

   // a transaction keeps the sequencer busy in the cycle after it is accepted
   `ACSD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // the reported size never exceeds the table depth
   `ACSD_ASSERT_IMPL(a_size_bound, clock, reset, rsp_valid, rsp_data.table_size <= SIZE_W'(DEPTH))
   // a found position lies inside the table
   `ACSD_ASSERT_IMPL(a_pos_range, clock, reset, rsp_valid && rsp_data.result_kind == KIND_FOUND, rsp_data.result_value != '0 && rsp_data.result_value <= rsp_data.table_size)
   // only search can give more than one result per request
   `ACSD_ASSERT_IMPL(a_single_last, clock, reset, rsp_valid && rsp_data.result_kind != KIND_FOUND, rsp_data.last_result)

endmodule

`default_nettype wire

// ----- bench/array_count_search_delete_test.sv -----
// self-checking testbench for the array count/search/delete block
`timescale 1ns / 100ps

module array_count_search_delete_test;
   import acsd_pkg::*;

   localparam int DEPTH       = 64;
   localparam int POOL_N      = 6;
   localparam int ITEM_TARGET = 470;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } directed_row;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req       = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp;

   // shadow copy of the table
   logic signed [DATA_W-1:0] model_entries [DEPTH];
   int                       model_fill = 0;

   rsp_type                  pending_results [$];
   directed_row              plan [$];
   logic signed [DATA_W-1:0] value_pool [POOL_N];
   rsp_type                  head_result;
   int                       failures     = 0;
   int                       items_sent   = 0;
   bit                       sender_quiet = 1'b0;
   bit                       sink_quiet   = 1'b0;
   int                       stall_left   = 0;
   int                       sink_roll;

   always #5 clock = ~clock;

   array_count_search_delete #(.DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp)
   );

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // computes the results of one request and updates the shadow table
   task automatic predict_table_op(input req_type r, input bit keep);
      logic signed [DATA_W-1:0] v;
      rsp_type                  res;
      rsp_type                  outs [$];
      int                       hits;
      int                       w;
      int                       idx;
      v = r.operand_value;
      res = '0;
      res.last_result = 1'b1;
      hits = 0;
      case (r.opcode)
         OP_CLEAR: begin
            model_fill = 0;
            res.result_kind = KIND_ACK;
         end
         OP_APPEND: begin
            if (model_fill >= DEPTH) begin
               res.result_kind = KIND_FULL;
            end else begin
               model_entries[model_fill] = v;
               model_fill++;
               res.result_kind = KIND_ACK;
            end
         end
         OP_COUNT: begin
            for (int i = 0; i < model_fill; i++)
               if (model_entries[i] == v) hits++;
            res.result_kind = KIND_COUNT;
            res.result_value = SIZE_W'(hits);
         end
         OP_SEARCH: begin
            for (int i = 0; i < model_fill; i++) begin
               if (model_entries[i] == v) begin
                  res.result_kind = KIND_FOUND;
                  res.result_value = SIZE_W'(i + 1);
                  res.last_result = 1'b0;
                  outs.push_back(res);
               end
            end
            if (outs.size() == 0) begin
               res.result_kind = KIND_NOT_FOUND;
               res.last_result = 1'b1;
            end else begin
               res = outs.pop_back();
               res.last_result = 1'b1;
            end
         end
         OP_DEL_FIRST: begin
            idx = -1;
            for (int i = 0; i < model_fill && idx < 0; i++)
               if (model_entries[i] == v) idx = i;
            if (idx >= 0) begin
               for (int j = idx; j + 1 < model_fill; j++)
                  model_entries[j] = model_entries[j + 1];
               model_fill--;
            end
            res.result_kind = KIND_DELETED;
            res.result_value = (idx >= 0) ? SIZE_W'(1) : SIZE_W'(0);
         end
         OP_DEL_ALL: begin
            w = 0;
            for (int i = 0; i < model_fill; i++) begin
               if (model_entries[i] != v) begin
                  model_entries[w] = model_entries[i];
                  w++;
               end
            end
            res.result_kind = KIND_DELETED;
            res.result_value = SIZE_W'(model_fill - w);
            model_fill = w;
         end
         default: res.result_kind = KIND_ACK;
      endcase
      outs.push_back(res);
      foreach (outs[k]) outs[k].table_size = SIZE_W'(model_fill);
      if (keep) foreach (outs[k]) pending_results.push_back(outs[k]);
   endtask

   function automatic int pick_gap();
      int r;
      if (sender_quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 4) return OP_CLEAR;
      if (r < 40) return OP_APPEND;
      if (r < 54) return OP_COUNT;
      if (r < 70) return OP_SEARCH;
      if (r < 84) return OP_DEL_FIRST;
      if (r < 96) return OP_DEL_ALL;
      return r[0] ? OP_SPARE_LO : OP_SPARE_HI;
   endfunction

   // mostly values that are likely to be stored, so that matches are common
   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 55) return value_pool[$urandom_range(POOL_N - 1)];
      if (r < 80 && model_fill > 0) return model_entries[$urandom_range(model_fill - 1)];
      return $urandom;
   endfunction

   function automatic void plan_fixed(input logic [OP_W-1:0] op,
                                      input logic signed [DATA_W-1:0] v,
                                      input logic [KIND_W-1:0] kind,
                                      input int value, input int size);
      directed_row row;
      row.item = '{opcode: op, operand_value: v};
      row.fixed = 1'b1;
      row.want = '{result_kind: kind, result_value: SIZE_W'(value),
                   table_size: SIZE_W'(size), last_result: 1'b1};
      plan.push_back(row);
   endfunction

   function automatic void plan_predicted(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] v);
      directed_row row;
      row.item = '{opcode: op, operand_value: v};
      row.fixed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   // presents one request at a falling edge and returns at a falling edge
   task automatic issue(input req_type r, input bit fixed, input rsp_type want);
      int gap;
      req <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (fixed) begin
         predict_table_op(r, 1'b0);
         pending_results.push_back(want);
      end else begin
         predict_table_op(r, 1'b1);
      end
      if (r.opcode <= OP_DEL_ALL) items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic run_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
      issue('{opcode: op, operand_value: v}, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // result side: random stalls, occasionally a long one, with quiet stretches
   always @(negedge clock) begin
      if ($urandom_range(199) == 0) sink_quiet = !sink_quiet;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!sink_quiet) begin
            sink_roll = $urandom_range(99);
            if (sink_roll < 25) stall_left = $urandom_range(1, 3);
            else if (sink_roll < 28) stall_left = $urandom_range(10, 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected transaction: kind %0d value %0d size %0d last %0d",
                                   rsp.result_kind, rsp.result_value, rsp.table_size,
                                   rsp.last_result));
         end else begin
            head_result = pending_results.pop_front();
            if (rsp.result_kind !== head_result.result_kind ||
                rsp.result_value !== head_result.result_value ||
                rsp.table_size !== head_result.table_size ||
                rsp.last_result !== head_result.last_result)
               note_failure($sformatf({"mismatch: expected kind %0d value %0d size %0d last %0d,",
                                       " got kind %0d value %0d size %0d last %0d"},
                                      head_result.result_kind, head_result.result_value,
                                      head_result.table_size, head_result.last_result,
                                      rsp.result_kind, rsp.result_value, rsp.table_size,
                                      rsp.last_result));
         end
      end
   end

   initial begin : stimulus
      logic signed [DATA_W-1:0] fill_value;
      int                       roll;

      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7fff_ffff;
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;

      // empty table after reset
      plan_fixed(OP_COUNT, 32'sd0, KIND_COUNT, 0, 0);
      plan_fixed(OP_SEARCH, 32'sd0, KIND_NOT_FOUND, 0, 0);
      plan_fixed(OP_DEL_FIRST, 32'sd5, KIND_DELETED, 0, 0);
      plan_fixed(OP_DEL_ALL, 32'sd5, KIND_DELETED, 0, 0);
      plan_fixed(OP_SPARE_LO, -32'sd1, KIND_ACK, 0, 0);
      // extremes, with adjacent duplicates
      plan_fixed(OP_APPEND, 32'h8000_0000, KIND_ACK, 0, 1);
      plan_fixed(OP_APPEND, 32'h7fff_ffff, KIND_ACK, 0, 2);
      plan_fixed(OP_APPEND, 32'sd0, KIND_ACK, 0, 3);
      plan_fixed(OP_APPEND, -32'sd1, KIND_ACK, 0, 4);
      plan_fixed(OP_APPEND, -32'sd1, KIND_ACK, 0, 5);
      plan_fixed(OP_APPEND, 32'h7fff_ffff, KIND_ACK, 0, 6);
      plan_fixed(OP_APPEND, -32'sd1, KIND_ACK, 0, 7);
      plan_predicted(OP_COUNT, -32'sd1);
      plan_predicted(OP_SEARCH, -32'sd1);
      plan_predicted(OP_SEARCH, 32'h8000_0000);
      plan_predicted(OP_SEARCH, 32'h7fff_fffe);
      plan_predicted(OP_DEL_FIRST, 32'h7fff_ffff);
      plan_predicted(OP_DEL_ALL, -32'sd1);
      plan_predicted(OP_COUNT, -32'sd1);
      plan_fixed(OP_SPARE_HI, 32'h5555_5555, KIND_ACK, 0, 3);
      plan_predicted(OP_DEL_FIRST, 32'h8000_0000);
      // clear leaves stale entries that must stay invisible
      plan_fixed(OP_CLEAR, 32'h7fff_ffff, KIND_ACK, 0, 0);
      plan_fixed(OP_SEARCH, 32'sd0, KIND_NOT_FOUND, 0, 0);
      plan_fixed(OP_COUNT, 32'sd0, KIND_COUNT, 0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) issue(plan[i].item, plan[i].fixed, plan[i].want);

      // full table of one value: every search hit and every delete at its widest
      drain_results();
      fill_value = $urandom;
      while (model_fill < DEPTH) run_op(OP_APPEND, fill_value);
      run_op(OP_APPEND, fill_value);
      run_op(OP_SEARCH, fill_value);
      run_op(OP_COUNT, fill_value);
      run_op(OP_DEL_FIRST, fill_value);
      run_op(OP_APPEND, ~fill_value);
      run_op(OP_SEARCH, ~fill_value);
      run_op(OP_DEL_ALL, fill_value);
      run_op(OP_COUNT, fill_value);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(39) == 0) sender_quiet = !sender_quiet;
         roll = $urandom_range(99);
         if (roll == 0) begin
            // fill to the brim from the pool, then one append too many
            while (model_fill < DEPTH) run_op(OP_APPEND, value_pool[$urandom_range(POOL_N - 1)]);
            run_op(OP_APPEND, pick_value());
         end else if (roll < 3) begin
            drain_results();
            run_op(pick_op(), pick_value());
         end else begin
            run_op(pick_op(), pick_value());
         end
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // worst case is far below this: ~470 items, each at most 64 stalled transactions
   initial begin : watchdog
      #50_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/acsd_pkg.sv
rtl/acsd_mem.sv
rtl/acsd_walk.sv
rtl/acsd_rsp_reg.sv
rtl/array_count_search_delete.sv
bench/array_count_search_delete_test.sv
